[sv/tll_pkg.sv]
package tll_pkg;

  // Longest kept name
  localparam int MaxNameDef = 255;

  // Result queue geometry
  localparam int QDepth = 4;
  localparam int QAddrW = 2;

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

  // Character codes
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNul     = 8'h00;

  // Result kinds
  localparam logic [1:0] RkNameByte = 2'd0;
  localparam logic [1:0] RkToken    = 2'd1;
  localparam logic [1:0] RkDrop     = 2'd2;

  // Token kinds
  localparam logic [3:0] TkIdent    = 4'd0;
  localparam logic [3:0] TkKwNum    = 4'd1;
  localparam logic [3:0] TkKwString = 4'd2;
  localparam logic [3:0] TkNumber   = 4'd3;
  localparam logic [3:0] TkStrLit   = 4'd4;
  localparam logic [3:0] TkSemi     = 4'd5;
  localparam logic [3:0] TkEq       = 4'd6;
  localparam logic [3:0] TkLParen   = 4'd7;
  localparam logic [3:0] TkRParen   = 4'd8;
  localparam logic [3:0] TkLBrace   = 4'd9;
  localparam logic [3:0] TkRBrace   = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [3:0]  token_kind;
    logic [30:0] number_value;
    logic [7:0]  name_length;
    logic        name_truncated;
    logic        last_of_run;
  } result_t;

  // Results of one scanned byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } scan_out_t;

  // Spelling of keyword num
  function automatic logic [7:0] kw_num_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6E;
      2'd1:    c = 8'h75;
      2'd2:    c = 8'h6D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Spelling of keyword string
  function automatic logic [7:0] kw_string_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h6E;
      3'd5:    c = 8'h67;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Punctuation token for a byte, TkIdent when none
  function automatic logic [3:0] punct_kind(input logic [7:0] b);
    logic [3:0] tk;
    unique case (b)
      ChSemi:   tk = TkSemi;
      ChEq:     tk = TkEq;
      ChLParen: tk = TkLParen;
      ChRParen: tk = TkRParen;
      ChLBrace: tk = TkLBrace;
      ChRBrace: tk = TkRBrace;
      default:  tk = TkIdent;
    endcase
    return tk;
  endfunction

endpackage

[sv/tll_scan.sv]
module tll_scan import tll_pkg::*; #(
  parameter int MAX_NAME = MaxNameDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] text_q,
  input  logic       eot_q,
  output scan_out_t  scan
);

  // Lexer state
  logic        in_str, in_str_next;
  logic [7:0]  wlen, wlen_next;
  logic        all_dig, all_dig_next;
  logic        m_num, m_num_next;
  logic        m_str, m_str_next;
  logic [30:0] acc, acc_next;
  logic        ovf, ovf_next;

  // Byte classes
  logic        eot, is_dig, is_alnum, is_punct;
  logic [3:0]  pk;
  assign eot      = eot_q || (text_q == ChNul);
  assign is_dig   = (text_q >= 8'h30) && (text_q <= 8'h39);
  assign is_alnum = is_dig || ((text_q >= 8'h61) && (text_q <= 8'h7A)) ||
                    ((text_q >= 8'h41) && (text_q <= 8'h5A));
  assign pk       = punct_kind(text_q);
  assign is_punct = (pk != TkIdent);

  // Decimal accumulate: acc * 10 + digit, saturated
  logic [34:0] acc_wide;
  logic [30:0] acc_sat;
  assign acc_wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, text_q[3:0]};
  assign acc_sat  = (acc_wide > {4'd0, ValueMax}) ? ValueMax : acc_wide[30:0];

  // Keyword prefix tracking
  logic pre_num, pre_str, at_max;
  assign pre_num = m_num && !ovf && (wlen < 8'd3) && (kw_num_char(wlen[1:0]) == text_q);
  assign pre_str = m_str && !ovf && (wlen < 8'd6) && (kw_string_char(wlen[2:0]) == text_q);
  assign at_max  = (wlen >= 8'(MAX_NAME));

  // Classification of the pending word
  result_t word_tok, str_tok, drop_res, name_res, punct_tok;
  always_comb begin
    word_tok = '0;
    word_tok.kind = RkToken;
    word_tok.name_length = wlen;
    word_tok.name_truncated = ovf;
    if (!ovf && m_num && (wlen == 8'd3)) begin
      word_tok.token_kind = TkKwNum;
    end else if (!ovf && m_str && (wlen == 8'd6)) begin
      word_tok.token_kind = TkKwString;
    end else if (all_dig) begin
      word_tok.token_kind = TkNumber;
      word_tok.number_value = acc;
    end else begin
      word_tok.token_kind = TkIdent;
    end
    str_tok = '0;
    str_tok.kind = RkToken;
    str_tok.token_kind = TkStrLit;
    str_tok.name_length = wlen;
    str_tok.name_truncated = ovf;
    drop_res = '0;
    drop_res.kind = RkDrop;
    drop_res.name_length = wlen;
    drop_res.name_truncated = ovf;
    name_res = '0;
    name_res.kind = RkNameByte;
    name_res.name_byte = text_q;
    punct_tok = '0;
    punct_tok.kind = RkToken;
    punct_tok.token_kind = pk;
  end

  // Next state and results
  always_comb begin
    logic clr;
    logic app;
    logic [1:0] n;
    result_t r0, r1;
    clr = 1'b0;
    app = 1'b0;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    in_str_next = in_str;
    if (eot) begin
      if (in_str) begin
        r0 = str_tok;
        n = 2'd1;
      end else if (wlen != 8'd0) begin
        r0 = word_tok;
        n = 2'd1;
      end
      clr = 1'b1;
      in_str_next = 1'b0;
    end else if (in_str) begin
      if (text_q == ChQuote) begin
        r0 = str_tok;
        n = 2'd1;
        clr = 1'b1;
        in_str_next = 1'b0;
      end else begin
        app = 1'b1;
      end
    end else if (text_q == ChQuote) begin
      if (wlen != 8'd0) begin
        r0 = drop_res;
        n = 2'd1;
      end
      clr = 1'b1;
      in_str_next = 1'b1;
    end else if (is_alnum) begin
      app = 1'b1;
    end else if (is_punct || (text_q == ChSpace) || (text_q == ChNewline)) begin
      if (wlen != 8'd0) begin
        r0 = word_tok;
        n = 2'd1;
        clr = 1'b1;
      end
      if (is_punct) begin
        if (n == 2'd0) begin
          r0 = punct_tok;
        end else begin
          r1 = punct_tok;
        end
        n = n + 2'd1;
      end
    end

    // Appending a byte to the word or string
    if (app && !at_max) begin
      r0 = name_res;
      n = 2'd1;
    end

    // Default: hold
    wlen_next    = wlen;
    all_dig_next = all_dig;
    m_num_next   = m_num;
    m_str_next   = m_str;
    acc_next     = acc;
    ovf_next     = ovf;
    if (clr) begin
      wlen_next    = 8'd0;
      all_dig_next = 1'b1;
      m_num_next   = 1'b1;
      m_str_next   = 1'b1;
      acc_next     = '0;
      ovf_next     = 1'b0;
    end else if (app) begin
      if (!in_str) begin
        if (is_dig) begin
          acc_next = acc_sat;
        end else begin
          all_dig_next = 1'b0;
        end
        m_num_next = pre_num;
        m_str_next = pre_str;
      end
      if (at_max) begin
        ovf_next = 1'b1;
      end else begin
        wlen_next = wlen + 8'd1;
      end
    end

    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
    scan.cnt = fire ? n : 2'd0;
    scan.r0  = r0;
    scan.r1  = r1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_str  <= 1'b0;
      wlen    <= 8'd0;
      all_dig <= 1'b1;
      m_num   <= 1'b1;
      m_str   <= 1'b1;
      acc     <= '0;
      ovf     <= 1'b0;
    end else if (fire) begin
      in_str  <= in_str_next;
      wlen    <= wlen_next;
      all_dig <= all_dig_next;
      m_num   <= m_num_next;
      m_str   <= m_str_next;
      acc     <= acc_next;
      ovf     <= ovf_next;
    end
  end

endmodule

[sv/tll_out_queue.sv]
module tll_out_queue import tll_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scan_out_t scan,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output result_t   head
);

  result_t            mem [QDepth];
  logic [QAddrW-1:0]  wp, rp;
  logic [QAddrW:0]    count;
  logic               pop;

  // Room for a full two-result push
  assign room      = (count <= (QAddrW+1)'(QDepth - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rp];

  // Storage writes
  always_ff @(posedge clk) begin
    if (scan.cnt != 2'd0) begin
      mem[wp] <= scan.r0;
    end
    if (scan.cnt == 2'd2) begin
      mem[wp + QAddrW'(1)] <= scan.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + QAddrW'(scan.cnt);
      rp    <= rp + QAddrW'(pop);
      count <= count + (QAddrW+1)'(scan.cnt) - (QAddrW+1)'(pop);
    end
  end

endmodule

[sv/toy_language_lexer_unit.sv]
// Channel   Handshake                    Payload
// text      text_valid / text_stall      text_byte, end_of_text
// result    result_valid / result_stall  result_kind, name_byte, token_kind,
//                                        number_value, name_length,
//                                        name_truncated, last_of_run
//
// One byte per cycle while the queue has room: an input register feeds a combinational scan stage,
// whose one or two results go into a four-entry result queue.
// Between transfer in and first result out lie the input register and the result queue.
// A byte that yields two results presents them at the output one after the other.
// text_stall rises only while the queue lacks room for two results.
// Reset (rst, synchronous) empties the queue and returns the lexer to no
// pending word and no open string.
module toy_language_lexer_unit import tll_pkg::*; #(
  parameter int MAX_NAME = MaxNameDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_byte,
  output logic [3:0]  token_kind,
  output logic [30:0] number_value,
  output logic [7:0]  name_length,
  output logic        name_truncated,
  output logic        last_of_run
);

  logic       in_vld;
  logic [7:0] text_q;
  logic       eot_q;
  logic       room, fire, take;
  scan_out_t  scan;
  result_t    head;

  assign fire       = in_vld && room;
  assign text_stall = in_vld && !room;
  assign take       = text_valid && !text_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      text_q <= text_byte;
      eot_q  <= end_of_text;
    end
  end

  tll_scan #(.MAX_NAME(MAX_NAME)) u_scan (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .text_q (text_q),
    .eot_q  (eot_q),
    .scan   (scan)
  );

  tll_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan),
    .room      (room),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .head      (head)
  );

  assign result_kind    = head.kind;
  assign name_byte      = head.name_byte;
  assign token_kind     = head.token_kind;
  assign number_value   = head.number_value;
  assign name_length    = head.name_length;
  assign name_truncated = head.name_truncated;
  assign last_of_run    = head.last_of_run;

endmodule
